[rtl/wig_pkg.sv]
// ============================================================================
// wig_pkg: shared types and constants for the window IoU gate
// Register map, reset values and the pipeline control bundle.
// ============================================================================
package wig_pkg;

    // Default coordinate width in bits
    localparam int DEF_COORD_BITS = 12;

    // Width of Q0.16 fractions
    localparam int FRAC_W = 16;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Reset values of the thresholds
    localparam logic [FRAC_W-1:0] OVL_THR_RST  = 16'd39322;
    localparam logic [FRAC_W-1:0] CONF_THR_RST = 16'd19660;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_TRACK_VALID = 3'd0,
        REG_TRK_X       = 3'd1,
        REG_TRK_Y       = 3'd2,
        REG_TRK_W       = 3'd3,
        REG_TRK_H       = 3'd4,
        REG_OVL_THR     = 3'd5,
        REG_CONF_THR    = 3'd6
    } t_reg_idx;

    // Control bits that travel with each item down the pipeline
    typedef struct packed {
        logic valid;    // stage holds an item
        logic trk_ok;   // tracked box was valid for this item
        logic conf_hi;  // confidence above its threshold
    } t_ctl;

endpackage

[rtl/wig_regs.sv]
// ============================================================================
// wig_regs: configuration register file
// APB-style write/read access to the tracked box and thresholds.
// ============================================================================
module wig_regs #(
    parameter int COORD_BITS = wig_pkg::DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wig_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [wig_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [wig_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,
    output logic                                  o_track_valid,
    output logic signed [COORD_BITS:0]            o_trk_x,
    output logic signed [COORD_BITS:0]            o_trk_y,
    output logic [COORD_BITS-1:0]                 o_trk_w,
    output logic [COORD_BITS-1:0]                 o_trk_h,
    output logic [wig_pkg::FRAC_W-1:0]            o_ovl_thr,
    output logic [wig_pkg::FRAC_W-1:0]            o_conf_thr
);

    localparam int DW = wig_pkg::CFG_DATA_W;

    logic                       r_track_valid, n_track_valid;
    logic [COORD_BITS:0]        r_trk_x, n_trk_x;
    logic [COORD_BITS:0]        r_trk_y, n_trk_y;
    logic [COORD_BITS-1:0]      r_trk_w, n_trk_w;
    logic [COORD_BITS-1:0]      r_trk_h, n_trk_h;
    logic [wig_pkg::FRAC_W-1:0] r_ovl_thr, n_ovl_thr;
    logic [wig_pkg::FRAC_W-1:0] r_conf_thr, n_conf_thr;
    wig_pkg::t_reg_idx          reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = wig_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_track_valid = r_track_valid;
        n_trk_x       = r_trk_x;
        n_trk_y       = r_trk_y;
        n_trk_w       = r_trk_w;
        n_trk_h       = r_trk_h;
        n_ovl_thr     = r_ovl_thr;
        n_conf_thr    = r_conf_thr;
        if (wr_en) begin
            unique case (reg_idx)
                wig_pkg::REG_TRACK_VALID: n_track_valid = pwdata[0];
                wig_pkg::REG_TRK_X:       n_trk_x       = pwdata[COORD_BITS:0];
                wig_pkg::REG_TRK_Y:       n_trk_y       = pwdata[COORD_BITS:0];
                wig_pkg::REG_TRK_W:       n_trk_w       = pwdata[COORD_BITS-1:0];
                wig_pkg::REG_TRK_H:       n_trk_h       = pwdata[COORD_BITS-1:0];
                wig_pkg::REG_OVL_THR:     n_ovl_thr     = pwdata[wig_pkg::FRAC_W-1:0];
                wig_pkg::REG_CONF_THR:    n_conf_thr    = pwdata[wig_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_valid <= 1'b0;
            r_trk_x       <= '0;
            r_trk_y       <= '0;
            r_trk_w       <= '0;
            r_trk_h       <= '0;
            r_ovl_thr     <= wig_pkg::OVL_THR_RST;
            r_conf_thr    <= wig_pkg::CONF_THR_RST;
        end else begin
            r_track_valid <= n_track_valid;
            r_trk_x       <= n_trk_x;
            r_trk_y       <= n_trk_y;
            r_trk_w       <= n_trk_w;
            r_trk_h       <= n_trk_h;
            r_ovl_thr     <= n_ovl_thr;
            r_conf_thr    <= n_conf_thr;
        end
    end

    always_comb begin
        unique case (reg_idx)
            wig_pkg::REG_TRACK_VALID: prdata = {{(DW-1){1'b0}}, r_track_valid};
            wig_pkg::REG_TRK_X:       prdata = {{(DW-COORD_BITS-1){1'b0}}, r_trk_x};
            wig_pkg::REG_TRK_Y:       prdata = {{(DW-COORD_BITS-1){1'b0}}, r_trk_y};
            wig_pkg::REG_TRK_W:       prdata = {{(DW-COORD_BITS){1'b0}}, r_trk_w};
            wig_pkg::REG_TRK_H:       prdata = {{(DW-COORD_BITS){1'b0}}, r_trk_h};
            wig_pkg::REG_OVL_THR:     prdata = {{(DW-wig_pkg::FRAC_W){1'b0}}, r_ovl_thr};
            wig_pkg::REG_CONF_THR:    prdata = {{(DW-wig_pkg::FRAC_W){1'b0}}, r_conf_thr};
            default:                  prdata = '0;
        endcase
    end

    assign o_track_valid = r_track_valid;
    assign o_trk_x       = signed'(r_trk_x);
    assign o_trk_y       = signed'(r_trk_y);
    assign o_trk_w       = r_trk_w;
    assign o_trk_h       = r_trk_h;
    assign o_ovl_thr     = r_ovl_thr;
    assign o_conf_thr    = r_conf_thr;

endmodule

[rtl/wig_overlap.sv]
// ============================================================================
// wig_overlap: box edge and overlap stages
// Two stages: far edges, then overlap extents and both box areas.
// ============================================================================
module wig_overlap #(
    parameter int COORD_BITS = wig_pkg::DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [COORD_BITS-1:0]                 i_win_x,
    input  logic [COORD_BITS-1:0]                 i_win_y,
    input  logic [COORD_BITS-1:0]                 i_win_w,
    input  logic [COORD_BITS-1:0]                 i_win_h,
    input  logic [wig_pkg::FRAC_W-1:0]            i_confidence,
    input  logic                                  i_track_valid,
    input  logic signed [COORD_BITS:0]            i_trk_x,
    input  logic signed [COORD_BITS:0]            i_trk_y,
    input  logic [COORD_BITS-1:0]                 i_trk_w,
    input  logic [COORD_BITS-1:0]                 i_trk_h,
    input  logic [wig_pkg::FRAC_W-1:0]            i_conf_thr,
    output wig_pkg::t_ctl                         o_ctl,
    output logic signed [COORD_BITS+2:0]          o_ov_w,
    output logic signed [COORD_BITS+2:0]          o_ov_h,
    output logic [2*COORD_BITS-1:0]               o_win_area,
    output logic [2*COORD_BITS-1:0]               o_trk_area
);

    localparam int EW = COORD_BITS + 3;

    // Stage 1: edges
    wig_pkg::t_ctl               r_ctl1, n_ctl1;
    logic [COORD_BITS-1:0]       r_wx1, r_wy1, r_ww1, r_wh1;
    logic [COORD_BITS:0]         r_wr1, r_wb1;
    logic signed [COORD_BITS:0]  r_tx1, r_ty1;
    logic signed [COORD_BITS+1:0] r_tr1, r_tb1;
    logic [COORD_BITS-1:0]       r_tw1, r_th1;

    // Stage 2: overlap extents and areas
    wig_pkg::t_ctl               r_ctl2;
    logic signed [EW-1:0]        r_ow2, r_oh2;
    logic [2*COORD_BITS-1:0]     r_a1_2, r_a2_2;

    logic signed [EW-1:0] wl_e, wr_e, tl_e, tr_e, wt_e, wb_e, tt_e, tb_e;
    logic signed [EW-1:0] rmin, lmax, bmin, tmax;

    always_comb begin
        n_ctl1.valid   = i_valid;
        n_ctl1.trk_ok  = i_track_valid;
        n_ctl1.conf_hi = i_confidence > i_conf_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
        end
        r_wx1 <= i_win_x;
        r_wy1 <= i_win_y;
        r_ww1 <= i_win_w;
        r_wh1 <= i_win_h;
        r_wr1 <= {1'b0, i_win_x} + {1'b0, i_win_w};
        r_wb1 <= {1'b0, i_win_y} + {1'b0, i_win_h};
        r_tx1 <= i_trk_x;
        r_ty1 <= i_trk_y;
        r_tr1 <= {i_trk_x[COORD_BITS], i_trk_x} + signed'({2'b00, i_trk_w});
        r_tb1 <= {i_trk_y[COORD_BITS], i_trk_y} + signed'({2'b00, i_trk_h});
        r_tw1 <= i_trk_w;
        r_th1 <= i_trk_h;
    end

    // Bring all edges to one signed width
    always_comb begin
        wl_e = signed'({3'b000, r_wx1});
        wr_e = signed'({2'b00, r_wr1});
        tl_e = {{2{r_tx1[COORD_BITS]}}, r_tx1};
        tr_e = {r_tr1[COORD_BITS+1], r_tr1};
        wt_e = signed'({3'b000, r_wy1});
        wb_e = signed'({2'b00, r_wb1});
        tt_e = {{2{r_ty1[COORD_BITS]}}, r_ty1};
        tb_e = {r_tb1[COORD_BITS+1], r_tb1};
        rmin = (wr_e < tr_e) ? wr_e : tr_e;
        lmax = (wl_e > tl_e) ? wl_e : tl_e;
        bmin = (wb_e < tb_e) ? wb_e : tb_e;
        tmax = (wt_e > tt_e) ? wt_e : tt_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= r_ctl1;
        end
        r_ow2  <= rmin - lmax;
        r_oh2  <= bmin - tmax;
        r_a1_2 <= r_ww1 * r_wh1;
        r_a2_2 <= r_tw1 * r_th1;
    end

    assign o_ctl      = r_ctl2;
    assign o_ov_w     = r_ow2;
    assign o_ov_h     = r_oh2;
    assign o_win_area = r_a1_2;
    assign o_trk_area = r_a2_2;

endmodule

[rtl/wig_iou.sv]
// ============================================================================
// wig_iou: union and ratio test stages
// Intersection, union, threshold product and final compare, four stages.
// ============================================================================
module wig_iou #(
    parameter int COORD_BITS = wig_pkg::DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wig_pkg::t_ctl                         i_ctl,
    input  logic signed [COORD_BITS+2:0]          i_ov_w,
    input  logic signed [COORD_BITS+2:0]          i_ov_h,
    input  logic [2*COORD_BITS-1:0]               i_win_area,
    input  logic [2*COORD_BITS-1:0]               i_trk_area,
    input  logic [wig_pkg::FRAC_W-1:0]            i_ovl_thr,
    output logic                                  o_valid,
    output logic                                  o_keep,
    output logic                                  o_overlaps_track
);

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;
    localparam int PW = UW + wig_pkg::FRAC_W;

    // Stage 3
    wig_pkg::t_ctl   r_ctl3;
    logic            r_pos3;
    logic [AW-1:0]   r_inter3;
    logic [UW-1:0]   r_sum3;
    // Stage 4
    wig_pkg::t_ctl   r_ctl4;
    logic            r_pos4;
    logic [AW-1:0]   r_inter4;
    logic [UW-1:0]   r_uni4;
    // Stage 5
    wig_pkg::t_ctl   r_ctl5;
    logic            r_pos5, r_nz5;
    logic [AW-1:0]   r_inter5;
    logic [PW-1:0]   r_prod5;
    // Stage 6 (output)
    logic            r_valid6, r_keep6, r_ovl6;

    logic            pos;
    logic            ovl;
    logic [PW-1:0]   inter_sh;

    // Overlap is positive only when both extents are above zero
    assign pos = !i_ov_w[COORD_BITS+2] && (i_ov_w != '0)
              && !i_ov_h[COORD_BITS+2] && (i_ov_h != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else begin
            r_ctl3 <= i_ctl;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
        end
        r_pos3   <= pos;
        r_inter3 <= pos ? (i_ov_w[COORD_BITS-1:0] * i_ov_h[COORD_BITS-1:0]) : '0;
        r_sum3   <= {1'b0, i_win_area} + {1'b0, i_trk_area};

        r_pos4   <= r_pos3;
        r_inter4 <= r_inter3;
        r_uni4   <= r_sum3 - {1'b0, r_inter3};

        r_pos5   <= r_pos4;
        r_nz5    <= r_uni4 != '0;
        r_inter5 <= r_inter4;
        r_prod5  <= i_ovl_thr * r_uni4;
    end

    assign inter_sh = {1'b0, r_inter5, {wig_pkg::FRAC_W{1'b0}}};
    assign ovl      = r_ctl5.trk_ok && r_pos5 && r_nz5 && (inter_sh > r_prod5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid6 <= 1'b0;
        end else begin
            r_valid6 <= r_ctl5.valid;
        end
        r_keep6 <= r_ctl5.conf_hi || ovl;
        r_ovl6  <= ovl;
    end

    assign o_valid          = r_valid6;
    assign o_keep           = r_keep6;
    assign o_overlaps_track = r_ovl6;

`ifndef SYNTH
    // Intersection never exceeds the sum of both areas
    a_union_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl3.valid |-> (r_sum3 >= {1'b0, r_inter3}))
        else $error("wig_iou: intersection larger than area sum");
`endif

endmodule

[rtl/window_iou_gate.sv]
// ============================================================================
// window_iou_gate: IoU gate for candidate windows
// Keeps a window on confidence or on overlap with the tracked box.
// ============================================================================
// Usage
//   Input: drive one candidate window (i_win_x/y/w/h, i_confidence) with
//   start high; it transfers at the edge where start is high and busy is low.
//   busy never rises, so a new window can transfer in every cycle.
//   Output: o_valid strobes for one cycle with o_keep and o_overlaps_track;
//   the receiver must take the result in that cycle, there is no stall.
//   Pipeline: a transferred window reaches the result ports through six
//   register stages. Throughput: one window per cycle, set by the fully
//   pipelined datapath: edges, overlap/areas, intersection, union,
//   threshold product, compare.
//   Configuration: APB-style, register i at byte address 4*i, pready tied
//   high. Write the tracked box and thresholds only while no window is in
//   flight. Reset (synchronous, active low) drops all in-flight windows and
//   loads the register reset values (thresholds about 0.6 and 0.3).
// ============================================================================
module window_iou_gate #(
    parameter int COORD_BITS = wig_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Window channel
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             i_win_x,
    input  logic [COORD_BITS-1:0]             i_win_y,
    input  logic [COORD_BITS-1:0]             i_win_w,
    input  logic [COORD_BITS-1:0]             i_win_h,
    input  logic [wig_pkg::FRAC_W-1:0]        i_confidence,
    // Result channel
    output logic                              o_valid,
    output logic                              o_keep,
    output logic                              o_overlaps_track,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wig_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wig_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wig_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic                        track_valid;
    logic signed [COORD_BITS:0]  trk_x, trk_y;
    logic [COORD_BITS-1:0]       trk_w, trk_h;
    logic [wig_pkg::FRAC_W-1:0]  ovl_thr, conf_thr;

    wig_pkg::t_ctl               ctl2;
    logic signed [COORD_BITS+2:0] ov_w, ov_h;
    logic [2*COORD_BITS-1:0]     win_area, trk_area;
    logic                        in_xfer;

    // The pipeline never stalls: the receiver must take every strobe; the block does not enforce this.
    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    wig_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_track_valid (track_valid),
        .o_trk_x       (trk_x),
        .o_trk_y       (trk_y),
        .o_trk_w       (trk_w),
        .o_trk_h       (trk_h),
        .o_ovl_thr     (ovl_thr),
        .o_conf_thr    (conf_thr)
    );

    // Stages 1-2: edges, overlap extents, box areas
    wig_overlap #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_xfer),
        .i_win_x       (i_win_x),
        .i_win_y       (i_win_y),
        .i_win_w       (i_win_w),
        .i_win_h       (i_win_h),
        .i_confidence  (i_confidence),
        .i_track_valid (track_valid),
        .i_trk_x       (trk_x),
        .i_trk_y       (trk_y),
        .i_trk_w       (trk_w),
        .i_trk_h       (trk_h),
        .i_conf_thr    (conf_thr),
        .o_ctl         (ctl2),
        .o_ov_w        (ov_w),
        .o_ov_h        (ov_h),
        .o_win_area    (win_area),
        .o_trk_area    (trk_area)
    );

    // Stages 3-6: intersection, union, threshold product, compare
    wig_iou #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl2),
        .i_ov_w           (ov_w),
        .i_ov_h           (ov_h),
        .i_win_area       (win_area),
        .i_trk_area       (trk_area),
        .i_ovl_thr        (ovl_thr),
        .o_valid          (o_valid),
        .o_keep           (o_keep),
        .o_overlaps_track (o_overlaps_track)
    );

`ifndef SYNTH
    // Every transfer yields its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##6 o_valid)
        else $error("window_iou_gate: result strobe missing");

    // No result strobe without a matching earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |-> ##6 !o_valid)
        else $error("window_iou_gate: unexpected result strobe");

    // An overlapping window is always kept
    a_ovl_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overlaps_track) |-> o_keep)
        else $error("window_iou_gate: overlap without keep");
`endif

endmodule

[tb/sv/tb_window_iou_gate.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_window_iou_gate: self-checking bench for the window IoU gate
// Drives candidate windows through the command port, programs the tracked
// box and thresholds over the APB-style port, predicts keep/overlap for
// each window and checks every result strobe against that prediction.
// ============================================================================
module tb_window_iou_gate;

    localparam int     CB          = wig_pkg::DEF_COORD_BITS;
    localparam int     FRAC_W      = wig_pkg::FRAC_W;
    localparam int     CFG_ADDR_W  = wig_pkg::CFG_ADDR_W;
    localparam int     CFG_DATA_W  = wig_pkg::CFG_DATA_W;
    localparam logic [FRAC_W-1:0] OVL_THR_RST  = wig_pkg::OVL_THR_RST;
    localparam logic [FRAC_W-1:0] CONF_THR_RST = wig_pkg::CONF_THR_RST;
    localparam longint COORD_MAX   = (longint'(1) << CB) - 1;
    localparam longint FRAC_MAX    = (longint'(1) << FRAC_W) - 1;
    // Six register stages; a little margin on top
    localparam int     PIPE_DEPTH  = 8;
    // Index just past the register list; writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd7;
    // Simulation-time guard, far beyond the slowest correct run
    localparam int     RUN_LIMIT_NS = 4_000_000;

    typedef struct packed {
        logic keep;
        logic overlaps_track;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   start        = 1'b0;
    logic                   busy;
    logic [CB-1:0]          i_win_x      = '0;
    logic [CB-1:0]          i_win_y      = '0;
    logic [CB-1:0]          i_win_w      = '0;
    logic [CB-1:0]          i_win_h      = '0;
    logic [FRAC_W-1:0]      i_confidence = '0;
    logic                   o_valid;
    logic                   o_keep;
    logic                   o_overlaps_track;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr        = '0;
    logic [CFG_DATA_W-1:0]  pwdata       = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    window_iou_gate uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_win_x          (i_win_x),
        .i_win_y          (i_win_y),
        .i_win_w          (i_win_w),
        .i_win_h          (i_win_h),
        .i_confidence     (i_confidence),
        .o_valid          (o_valid),
        .o_keep           (o_keep),
        .o_overlaps_track (o_overlaps_track),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow of the register file, kept in step with every write
    // ------------------------------------------------------------------------
    logic                 trk_on;
    logic signed [CB:0]   trk_x_q;
    logic signed [CB:0]   trk_y_q;
    logic [CB-1:0]        trk_w_q;
    logic [CB-1:0]        trk_h_q;
    logic [FRAC_W-1:0]    ovl_thr_q;
    logic [FRAC_W-1:0]    conf_thr_q;

    t_verdict expected_verdicts[$];
    int       fail_count = 0;

    // Predict keep and overlap for one window against the tracked box.
    // Everything is widened to 64 bits so the cross-multiplied compare
    // (overlap * 2^16 vs threshold * union) cannot wrap.
    function automatic t_verdict judge_window(input logic [CB-1:0] wx, wy, ww, wh,
                                              input logic [FRAC_W-1:0] conf);
        t_verdict v;
        longint   tx, ty, tw, th, lo, hi, ow, oh, inter, uni;
        logic     ovl;
        tx  = longint'(trk_x_q);
        ty  = longint'(trk_y_q);
        tw  = longint'(trk_w_q);
        th  = longint'(trk_h_q);
        ovl = 1'b0;
        if (trk_on) begin
            lo = (longint'(wx) > tx) ? longint'(wx) : tx;
            hi = (longint'(wx) + longint'(ww) < tx + tw) ? longint'(wx) + longint'(ww)
                                                          : tx + tw;
            ow = hi - lo;
            lo = (longint'(wy) > ty) ? longint'(wy) : ty;
            hi = (longint'(wy) + longint'(wh) < ty + th) ? longint'(wy) + longint'(wh)
                                                          : ty + th;
            oh = hi - lo;
            // Disjoint or edge-touching boxes contribute no overlap at all
            if (ow > 0 && oh > 0) begin
                inter = ow * oh;
                uni   = longint'(ww) * longint'(wh) + tw * th - inter;
                if (uni != 0 && (inter << FRAC_W) > longint'(ovl_thr_q) * uni)
                    ovl = 1'b1;
            end
        end
        v.overlaps_track = ovl;
        v.keep           = (conf > conf_thr_q) || ovl;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: outputs are sampled at the edge that ends their cycle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $error("o_valid: expected 0 or 1, got %b", o_valid);
                fail_count++;
            end else if (o_valid) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result strobe with no window outstanding: keep=%b overlaps_track=%b",
                           o_keep, o_overlaps_track);
                    fail_count++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (o_keep !== exp_v.keep) begin
                        $error("keep: expected %b, got %b", exp_v.keep, o_keep);
                        fail_count++;
                    end
                    if (o_overlaps_track !== exp_v.overlaps_track) begin
                        $error("overlaps_track: expected %b, got %b",
                               exp_v.overlaps_track, o_overlaps_track);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one window and hold it until the transfer edge, then record the
    // prediction. Entry must be in the time step of a rising edge.
    task automatic send_window(input logic [CB-1:0] wx, wy, ww, wh,
                               input logic [FRAC_W-1:0] conf);
        start        <= 1'b1;
        i_win_x      <= wx;
        i_win_y      <= wy;
        i_win_w      <= ww;
        i_win_h      <= wh;
        i_confidence <= conf;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expected_verdicts.insert(expected_verdicts.size(),
                                 judge_window(wx, wy, ww, wh, conf));
    endtask

    // Drop start and scramble the idle payload for a pause of length n
    task automatic pause_sender(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) begin
                i_win_x      <= CB'($urandom);
                i_win_y      <= CB'($urandom);
                i_win_w      <= CB'($urandom);
                i_win_h      <= CB'($urandom);
                i_confidence <= FRAC_W'($urandom);
                @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and hold until every outstanding window has reported back
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    // One APB write after a drain: setup, access, then bus idle. The
    // shadow copy takes the masked value at the edge the register is written.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            wig_pkg::REG_TRACK_VALID: trk_on     = value[0];
            wig_pkg::REG_TRK_X:       trk_x_q    = value[CB:0];
            wig_pkg::REG_TRK_Y:       trk_y_q    = value[CB:0];
            wig_pkg::REG_TRK_W:       trk_w_q    = value[CB-1:0];
            wig_pkg::REG_TRK_H:       trk_h_q    = value[CB-1:0];
            wig_pkg::REG_OVL_THR:     ovl_thr_q  = value[FRAC_W-1:0];
            wig_pkg::REG_CONF_THR:    conf_thr_q = value[FRAC_W-1:0];
            default:                  ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program the whole tracked box and both thresholds
    task automatic set_track(input logic on, input longint x, y, w, h,
                             input longint othr, cthr);
        write_reg(wig_pkg::REG_TRACK_VALID, CFG_DATA_W'(on));
        write_reg(wig_pkg::REG_TRK_X,       CFG_DATA_W'(x));
        write_reg(wig_pkg::REG_TRK_Y,       CFG_DATA_W'(y));
        write_reg(wig_pkg::REG_TRK_W,       CFG_DATA_W'(w));
        write_reg(wig_pkg::REG_TRK_H,       CFG_DATA_W'(h));
        write_reg(wig_pkg::REG_OVL_THR,     CFG_DATA_W'(othr));
        write_reg(wig_pkg::REG_CONF_THR,    CFG_DATA_W'(cthr));
    endtask

    function automatic logic [CB-1:0] clamp_coord(input longint v);
        if (v < 0)         return '0;
        if (v > COORD_MAX) return CB'(COORD_MAX);
        return CB'(v);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset tracking is off and the confidence threshold is about 0.3
    task automatic test_reset_defaults();
        send_window(CB'(0), CB'(0), CB'(0), CB'(0), FRAC_W'(CONF_THR_RST));
        send_window(CB'(0), CB'(0), CB'(0), CB'(0), FRAC_W'(CONF_THR_RST) + 1'b1);
        send_window(CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), '0);
        send_window(CB'(0), CB'(0), CB'(COORD_MAX), CB'(COORD_MAX), '1);
    endtask

    // Box geometry: identical, disjoint, touching edges, empty and full-range windows
    task automatic test_overlap_geometry();
        // Confidence can never exceed 65535, so keep follows the overlap flag
        set_track(1'b1, 100, 200, 50, 40, 32768, FRAC_MAX);
        send_window(CB'(100), CB'(200), CB'(50), CB'(40), '0);
        send_window(CB'(0),   CB'(0),   CB'(10), CB'(10), '1);
        send_window(CB'(150), CB'(200), CB'(50), CB'(40), '0);   // touches right edge
        send_window(CB'(100), CB'(240), CB'(50), CB'(40), '0);   // touches bottom edge
        send_window(CB'(110), CB'(210), CB'(0),  CB'(0),  '0);   // no area
        send_window(CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), '1);
        send_window(CB'(0), CB'(0), CB'(COORD_MAX), CB'(COORD_MAX), '0);
    endtask

    // Zero-size tracked box and zero-size window: the union is empty
    task automatic test_zero_union();
        write_reg(wig_pkg::REG_TRK_W, '0);
        write_reg(wig_pkg::REG_TRK_H, '0);
        write_reg(wig_pkg::REG_OVL_THR, '0);
        send_window(CB'(100), CB'(200), CB'(0), CB'(0), '0);
    endtask

    // IoU exactly at the threshold fails; one code lower passes
    task automatic test_threshold_edges();
        set_track(1'b1, 0, 0, 10, 10, 32768, 0);
        send_window(CB'(0), CB'(0), CB'(10), CB'(5), '0);        // IoU = 0.5
        write_reg(wig_pkg::REG_OVL_THR, CFG_DATA_W'(32767));
        send_window(CB'(0), CB'(0), CB'(10), CB'(5), FRAC_W'(1));
        write_reg(wig_pkg::REG_OVL_THR, '0);
        send_window(CB'(9), CB'(9), CB'(10), CB'(10), '0);       // single-pixel overlap
        write_reg(wig_pkg::REG_OVL_THR, CFG_DATA_W'(FRAC_MAX));
        send_window(CB'(0), CB'(0), CB'(10), CB'(10), '0);       // only a perfect match
        send_window(CB'(0), CB'(0), CB'(10), CB'(9),  '0);
    endtask

    // Tracked box partly or fully off frame, at both signed extremes
    task automatic test_off_frame_track();
        set_track(1'b1, -4096, -4096, COORD_MAX, COORD_MAX, 0, FRAC_MAX);
        send_window(CB'(0), CB'(0), CB'(20), CB'(20), '0);       // box ends one short of origin
        set_track(1'b1, -10, -5, 20, 20, 16384, FRAC_MAX);
        send_window(CB'(0), CB'(0), CB'(10), CB'(15), '0);
        set_track(1'b1, 4095, 4095, COORD_MAX, COORD_MAX, 0, FRAC_MAX);
        send_window(CB'(4000), CB'(4000), CB'(COORD_MAX), CB'(COORD_MAX), '0);
    endtask

    // A write past the register list and excess data bits change nothing
    task automatic test_ignored_writes();
        set_track(1'b1, 0, 0, 10, 10, 32768, 100);
        write_reg(REG_SPARE, '1);
        write_reg(wig_pkg::REG_TRK_W, {{(CFG_DATA_W-CB){1'b1}}, CB'(10)});
        send_window(CB'(0), CB'(0), CB'(10), CB'(10), FRAC_W'(100));
    endtask

    // With tracking off a perfect match is ignored and confidence decides
    task automatic test_tracking_off();
        write_reg(wig_pkg::REG_TRACK_VALID, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
        send_window(CB'(0), CB'(0), CB'(10), CB'(10), FRAC_W'(100));
        send_window(CB'(0), CB'(0), CB'(10), CB'(10), FRAC_W'(101));
    endtask

    // Pick a tracked box and thresholds, extremes included, and program them
    // with random junk above each field
    task automatic load_random_setup(input logic tracking);
        logic [CFG_DATA_W-1:0] v;
        longint                pick;
        v    = $urandom;
        v[0] = tracking;
        write_reg(wig_pkg::REG_TRACK_VALID, v);
        for (int axis = 0; axis < 2; axis++) begin
            pick = $urandom_range(0, 9);
            v    = $urandom;
            if (pick == 0)      v[CB:0] = {1'b1, {CB{1'b0}}};
            else if (pick == 1) v[CB:0] = {1'b0, {CB{1'b1}}};
            else if (pick < 4)  v[CB:0] = (CB+1)'($urandom);
            else                v[CB:0] = (CB+1)'($urandom_range(0, 3500));
            write_reg(axis == 0 ? wig_pkg::REG_TRK_X : wig_pkg::REG_TRK_Y, v);
            pick = $urandom_range(0, 19);
            v    = $urandom;
            if (pick == 0)      v[CB-1:0] = '0;
            else if (pick == 1) v[CB-1:0] = '1;
            else if (pick < 8)  v[CB-1:0] = CB'($urandom_range(1, 64));
            else                v[CB-1:0] = CB'($urandom_range(1, 800));
            write_reg(axis == 0 ? wig_pkg::REG_TRK_W : wig_pkg::REG_TRK_H, v);
        end
        for (int k = 0; k < 2; k++) begin
            pick = $urandom_range(0, 9);
            v    = $urandom;
            if (pick == 0)      v[FRAC_W-1:0] = '0;
            else if (pick == 1) v[FRAC_W-1:0] = '1;
            else if (pick == 2) v[FRAC_W-1:0] = (k == 0) ? OVL_THR_RST : CONF_THR_RST;
            write_reg(k == 0 ? wig_pkg::REG_OVL_THR : wig_pkg::REG_CONF_THR, v);
        end
    endtask

    // One random window, mostly clustered around the tracked box so the
    // overlap ratio sweeps across the threshold
    task automatic send_random_window();
        longint             tx, ty, tw, th, sx, sy;
        logic [CB-1:0]      wx, wy, ww, wh;
        logic [FRAC_W-1:0]  conf;
        int                 kind;
        tx   = longint'(trk_x_q);
        ty   = longint'(trk_y_q);
        tw   = longint'(trk_w_q);
        th   = longint'(trk_h_q);
        sx   = (tw / 4 > 4) ? tw / 4 : 4;
        sy   = (th / 4 > 4) ? th / 4 : 4;
        kind = $urandom_range(0, 99);
        wx   = clamp_coord(tx + jitter(sx));
        wy   = clamp_coord(ty + jitter(sy));
        ww   = clamp_coord(tw + jitter(sx));
        wh   = clamp_coord(th + jitter(sy));
        if (kind >= 55 && kind < 70) begin
            // Line the window up against one edge of the tracked box
            case ($urandom_range(0, 3))
                0: wx = clamp_coord(tx + tw);
                1: wx = clamp_coord(tx - longint'(ww));
                2: wy = clamp_coord(ty + th);
                default: wy = clamp_coord(ty - longint'(wh));
            endcase
        end else if (kind >= 70 && kind < 90) begin
            wx = CB'($urandom);
            wy = CB'($urandom);
            ww = CB'($urandom);
            wh = CB'($urandom);
        end else if (kind >= 90) begin
            case ($urandom_range(0, 3))
                0: ww = '0;
                1: wh = '0;
                2: begin wx = '1; wy = '1; end
                default: begin ww = '1; wh = '1; end
            endcase
        end
        case ($urandom_range(0, 3))
            0: conf = FRAC_W'(conf_thr_q + jitter(2));
            1: conf = $urandom_range(0, 1) ? '1 : '0;
            default: conf = FRAC_W'($urandom);
        endcase
        send_window(wx, wy, ww, wh, conf);
    endtask

    // A batch of random windows under one setup, with the sender idling in
    // idle_pct cycles of a hundred, broken up by gap-free bursts and the
    // odd full drain
    task automatic test_random_windows(input int count, input int idle_pct,
                                       input logic tracking);
        int burst_left;
        burst_left = 0;
        load_random_setup(tracking);
        for (int n = 0; n < count; n++) begin
            send_random_window();
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 149) == 0)
                wait_idle();
            else begin
                // Each cycle stays idle with probability idle_pct percent
                while ($urandom_range(0, 99) < idle_pct)
                    pause_sender(1);
                if ($urandom_range(0, 29) == 0)
                    burst_left = 20;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        trk_on     = 1'b0;
        trk_x_q    = '0;
        trk_y_q    = '0;
        trk_w_q    = '0;
        trk_h_q    = '0;
        ovl_thr_q  = OVL_THR_RST;
        conf_thr_q = CONF_THR_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_overlap_geometry();
        test_zero_union();
        test_threshold_edges();
        test_off_frame_track();
        test_ignored_writes();
        test_tracking_off();

        // Each phase drains fully before its setup is written, so the
        // sender also pauses until every result is back
        test_random_windows(125, 0,  1'b1);
        test_random_windows(125, 70, 1'b1);
        test_random_windows(125, 30, 1'b1);
        test_random_windows(125, 0,  1'b0);
        test_random_windows(125, 70, 1'b1);
        test_random_windows(125, 30, 1'b1);

        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hung handshake guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[window_iou_gate.f]
rtl/wig_pkg.sv
rtl/wig_regs.sv
rtl/wig_overlap.sv
rtl/wig_iou.sv
rtl/window_iou_gate.sv
tb/sv/tb_window_iou_gate.sv
